// File: rtl/core/segi_pkg.sv
// segi_pkg: shared constants and types of the segment intersection unit
// used by segi_front, segi_div and segment_intersection_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package segi_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int OUT_WIDTH       = 32;

	typedef struct packed {
		logic hit;
		logic degen;
		logic neg_x;
		logic neg_y;
	} segi_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/segi_front.sv
// segi_front: cross products, orientation and crossing decision, numerator products
// four register stages; depends on segi_pkg
`timescale 1ns / 1ps
`default_nettype none

module segi_front import segi_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic signed [W-1:0]     ax1,
	input  wire logic signed [W-1:0]     ay1,
	input  wire logic signed [W-1:0]     ax2,
	input  wire logic signed [W-1:0]     ay2,
	input  wire logic signed [W-1:0]     bx1,
	input  wire logic signed [W-1:0]     by1,
	input  wire logic signed [W-1:0]     bx2,
	input  wire logic signed [W-1:0]     by2,
	output logic                         valid_s4,
	output segi_flags_t                  flags_s4,
	output logic signed [W-1:0]          basex_s4,
	output logic signed [W-1:0]          basey_s4,
	output logic [3*W+3:0]               px_s4,
	output logic [3*W+3:0]               py_s4,
	output logic [2*W+2:0]               dm_s4
);

	localparam int CW = 2*W + 3;
	localparam int CL = W + 2;
	localparam int PW = 3*W + 4;

	function automatic logic signed [W:0] dif(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return {a[W-1], a} - {b[W-1], b};
	endfunction

	function automatic logic signed [2*W+1:0] mul(input logic signed [W:0] a,
			input logic signed [W:0] b);
		logic signed [2*W+1:0] r;
		r = a * b;
		return r;
	endfunction

	// q within the closed box of p..r, ends excluded
	function automatic logic on_seg(input logic signed [W-1:0] px,
			input logic signed [W-1:0] py, input logic signed [W-1:0] qx,
			input logic signed [W-1:0] qy, input logic signed [W-1:0] rx,
			input logic signed [W-1:0] ry);
		return !(px == qx && py == qy) && !(qx == rx && qy == ry) &&
			(qx <= px || qx <= rx) && (qx >= px || qx >= rx) &&
			(qy <= py || qy <= ry) && (qy >= py || qy >= ry);
	endfunction

	// stage 1
	logic signed [2*W+1:0] prod_s1 [0:11];
	logic                  valid_s1, shared_s1;
	logic [3:0]            os_s1;
	logic signed [W:0]     dx_s1, dy_s1;
	logic signed [W-1:0]   basex_s1, basey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0]  <= mul(dif(ay2, ay1), dif(bx1, ax2));
			prod_s1[1]  <= mul(dif(ax2, ax1), dif(by1, ay2));
			prod_s1[2]  <= mul(dif(ay2, ay1), dif(bx2, ax2));
			prod_s1[3]  <= mul(dif(ax2, ax1), dif(by2, ay2));
			prod_s1[4]  <= mul(dif(by2, by1), dif(ax1, bx2));
			prod_s1[5]  <= mul(dif(bx2, bx1), dif(ay1, by2));
			prod_s1[6]  <= mul(dif(by2, by1), dif(ax2, bx2));
			prod_s1[7]  <= mul(dif(bx2, bx1), dif(ay2, by2));
			prod_s1[8]  <= mul(dif(ax1, ax2), dif(by1, by2));
			prod_s1[9]  <= mul(dif(ay1, ay2), dif(bx1, bx2));
			prod_s1[10] <= mul(dif(bx1, ax1), dif(by2, ay1));
			prod_s1[11] <= mul(dif(by1, ay1), dif(bx2, ax1));
			shared_s1 <= (ax1 == bx1 && ay1 == by1) || (ax1 == bx2 && ay1 == by2) ||
				(ax2 == bx1 && ay2 == by1) || (ax2 == bx2 && ay2 == by2);
			os_s1[0] <= on_seg(ax1, ay1, bx1, by1, ax2, ay2);
			os_s1[1] <= on_seg(ax1, ay1, bx2, by2, ax2, ay2);
			os_s1[2] <= on_seg(bx1, by1, ax1, ay1, bx2, by2);
			os_s1[3] <= on_seg(bx1, by1, ax2, ay2, bx2, by2);
			dx_s1    <= dif(ax2, ax1);
			dy_s1    <= dif(ay2, ay1);
			basex_s1 <= ax1;
			basey_s1 <= ay1;
		end
	end

	// stage 2: orientation classes, crossing decision, magnitudes
	logic signed [CW-1:0] v [0:5];
	logic [5:0]           z;
	logic                 same01, same23, hit, neg_x, neg_y;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			v[i] = CW'(prod_s1[2*i]) - CW'(prod_s1[2*i+1]);
			z[i] = (v[i] == '0);
		end
		same01 = (z[0] && z[1]) || (!z[0] && !z[1] && (v[0][CW-1] == v[1][CW-1]));
		same23 = (z[2] && z[3]) || (!z[2] && !z[3] && (v[2][CW-1] == v[3][CW-1]));
		hit = !shared_s1 && ((!same01 && !same23) || (z[0] && os_s1[0]) ||
			(z[1] && os_s1[1]) || (z[2] && os_s1[2]) || (z[3] && os_s1[3]));
		neg_x = dx_s1[W] ^ v[5][CW-1] ^ v[4][CW-1];
		neg_y = dy_s1[W] ^ v[5][CW-1] ^ v[4][CW-1];
	end

	logic                valid_s2;
	segi_flags_t         flags_s2;
	logic [W:0]          dxm_s2, dym_s2;
	logic [CW-1:0]       cm_s2, dm_s2;
	logic signed [W-1:0] basex_s2, basey_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2.hit   <= hit;
			flags_s2.degen <= hit && z[4];
			flags_s2.neg_x <= neg_x;
			flags_s2.neg_y <= neg_y;
			dxm_s2   <= dx_s1[W] ? -dx_s1 : dx_s1;
			dym_s2   <= dy_s1[W] ? -dy_s1 : dy_s1;
			cm_s2    <= v[5][CW-1] ? -v[5] : v[5];
			dm_s2    <= v[4][CW-1] ? -v[4] : v[4];
			basex_s2 <= basex_s1;
			basey_s2 <= basey_s1;
		end
	end

	// stage 3: numerator partial products, c split in two halves
	logic                valid_s3;
	segi_flags_t         flags_s3;
	logic [2*W+2:0]      pxl_s3, pyl_s3;
	logic [2*W+1:0]      pxh_s3, pyh_s3;
	logic [CW-1:0]       dm_s3;
	logic signed [W-1:0] basex_s3, basey_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= flags_s2;
			pxl_s3   <= (2*W+3)'(dxm_s2) * (2*W+3)'(cm_s2[CL-1:0]);
			pyl_s3   <= (2*W+3)'(dym_s2) * (2*W+3)'(cm_s2[CL-1:0]);
			pxh_s3   <= (2*W+2)'(dxm_s2) * (2*W+2)'(cm_s2[CW-1:CL]);
			pyh_s3   <= (2*W+2)'(dym_s2) * (2*W+2)'(cm_s2[CW-1:CL]);
			dm_s3    <= dm_s2;
			basex_s3 <= basex_s2;
			basey_s3 <= basey_s2;
		end
	end

	// stage 4: full numerator magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4 <= flags_s3;
			px_s4    <= PW'(pxl_s3) + (PW'(pxh_s3) << CL);
			py_s4    <= PW'(pyl_s3) + (PW'(pyh_s3) << CL);
			dm_s4    <= dm_s3;
			basex_s4 <= basex_s3;
			basey_s4 <= basey_s3;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/segi_div.sv
// segi_div: pipelined restoring divider, one quotient bit per stage
// quotient of (p << F) / dm; depends on segi_pkg
`timescale 1ns / 1ps
`default_nettype none

module segi_div import segi_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [3*W+3:0]   p_in,
	input  wire logic [2*W+2:0]   dm_in,
	output logic [W+F:0]          q,
	output logic                  rem_nz
);

	localparam int QW = W + F + 1;
	localparam int DW = 2*W + 3;

	logic [DW-1:0] rem_s [0:QW-1];
	logic [QW-1:0] low_s [0:QW-1];
	logic [QW-1:0] q_s   [0:QW-1];
	logic [DW-1:0] dm_s  [0:QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_i, dm_i;
		logic [QW-1:0] low_i, q_i;
		logic [DW:0]   trial, diff;
		logic          ge;

		if (k == 0) begin : g_first
			// upper part of the dividend is already below the divisor
			assign rem_i = p_in[3*W+3:W+1];
			assign low_i = QW'(p_in[W:0]) << F;
			assign q_i   = '0;
			assign dm_i  = dm_in;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign q_i   = q_s[k-1];
			assign dm_i  = dm_s[k-1];
		end

		assign trial = {rem_i, low_i[QW-1]};
		assign diff  = trial - {1'b0, dm_i};
		assign ge    = (trial >= {1'b0, dm_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				low_s[k] <= low_i << 1;
				q_s[k]   <= {q_i[QW-2:0], ge};
				dm_s[k]  <= dm_i;
			end
		end
	end

	assign q      = q_s[QW-1];
	assign rem_nz = |rem_s[QW-1];

endmodule

`default_nettype wire

// File: rtl/core/segment_intersection_unit.sv
// segment_intersection_unit: segment crossing test with fixed-point intersection point
// pipeline of four front stages, one divider stage per quotient bit, one output register
// throughput one request per cycle; the whole pipeline holds while a result is stalled
// asynchronous active-low reset clears all valid bits; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_unit import segi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] ax1,
	input  wire logic signed [COORD_WIDTH-1:0] ay1,
	input  wire logic signed [COORD_WIDTH-1:0] ax2,
	input  wire logic signed [COORD_WIDTH-1:0] ay2,
	input  wire logic signed [COORD_WIDTH-1:0] bx1,
	input  wire logic signed [COORD_WIDTH-1:0] by1,
	input  wire logic signed [COORD_WIDTH-1:0] bx2,
	input  wire logic signed [COORD_WIDTH-1:0] by2,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               crosses,
	output logic                               degenerate,
	output logic signed [OUT_WIDTH-1:0]        ix,
	output logic signed [OUT_WIDTH-1:0]        iy
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int QW = W + F + 1;
	localparam int FW = (W + F + 4 > OUT_WIDTH) ? W + F + 4 : OUT_WIDTH;

	logic en;
	logic out_valid_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	logic                valid_s4;
	segi_flags_t         flags_s4;
	logic signed [W-1:0] basex_s4, basey_s4;
	logic [3*W+3:0]      px_s4, py_s4;
	logic [2*W+2:0]      dm_s4;

	segi_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.ax1      (ax1),
		.ay1      (ay1),
		.ax2      (ax2),
		.ay2      (ay2),
		.bx1      (bx1),
		.by1      (by1),
		.bx2      (bx2),
		.by2      (by2),
		.valid_s4 (valid_s4),
		.flags_s4 (flags_s4),
		.basex_s4 (basex_s4),
		.basey_s4 (basey_s4),
		.px_s4    (px_s4),
		.py_s4    (py_s4),
		.dm_s4    (dm_s4)
	);

	logic [QW-1:0] qx, qy;
	logic          rnz_x, rnz_y;

	segi_div #(.W(W), .F(F)) u_div_x (
		.clk    (clk),
		.en     (en),
		.p_in   (px_s4),
		.dm_in  (dm_s4),
		.q      (qx),
		.rem_nz (rnz_x)
	);

	segi_div #(.W(W), .F(F)) u_div_y (
		.clk    (clk),
		.en     (en),
		.p_in   (py_s4),
		.dm_in  (dm_s4),
		.q      (qy),
		.rem_nz (rnz_y)
	);

	// side data runs alongside the divider stages
	logic                vld_dly_s   [0:QW-1];
	segi_flags_t         flags_dly_s [0:QW-1];
	logic signed [W-1:0] bx_dly_s    [0:QW-1];
	logic signed [W-1:0] by_dly_s    [0:QW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				vld_dly_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_dly_s[0] <= valid_s4;
			for (int i = 1; i < QW; i++) begin
				vld_dly_s[i] <= vld_dly_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_dly_s[0] <= flags_s4;
			bx_dly_s[0]    <= basex_s4;
			by_dly_s[0]    <= basey_s4;
			for (int i = 1; i < QW; i++) begin
				flags_dly_s[i] <= flags_dly_s[i-1];
				bx_dly_s[i]    <= bx_dly_s[i-1];
				by_dly_s[i]    <= by_dly_s[i-1];
			end
		end
	end

	// base * 2^F plus signed quotient, truncated toward zero
	function automatic logic signed [FW-1:0] fix(input logic signed [W-1:0] base,
			input logic [QW-1:0] qm, input logic neg, input logic rnz);
		logic signed [FW-1:0] qs, fl, f;
		qs = signed'(FW'(qm));
		fl = neg ? -qs - FW'(rnz) : qs;
		f  = (FW'(base) <<< F) + fl;
		if (f < 0 && rnz) begin
			f = f + FW'(1);
		end
		return f;
	endfunction

	segi_flags_t          fl_last;
	logic signed [FW-1:0] fx, fy;
	logic                 point_ok;

	always_comb begin
		fl_last  = flags_dly_s[QW-1];
		fx       = fix(bx_dly_s[QW-1], qx, fl_last.neg_x, rnz_x);
		fy       = fix(by_dly_s[QW-1], qy, fl_last.neg_y, rnz_y);
		point_ok = fl_last.hit && !fl_last.degen;
	end

	logic                        crosses_q, degenerate_q;
	logic signed [OUT_WIDTH-1:0] ix_q, iy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_dly_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crosses_q    <= fl_last.hit;
			degenerate_q <= fl_last.degen;
			ix_q         <= point_ok ? fx[OUT_WIDTH-1:0] : '0;
			iy_q         <= point_ok ? fy[OUT_WIDTH-1:0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign crosses    = crosses_q;
	assign degenerate = degenerate_q;
	assign ix         = ix_q;
	assign iy         = iy_q;

endmodule

`default_nettype wire

// File: test/segment_intersection_unit_tb.sv
// segment_intersection_unit_tb: self-checking bench for the segment intersection unit
// drives directed and random segment pairs, predicts crossing flags and fixed-point point
// depends on segi_pkg and segment_intersection_unit
`timescale 1ns / 1ps

class segi_scoreboard;
	typedef struct {
		bit crosses;
		bit degenerate;
		bit [31:0] ix;
		bit [31:0] iy;
	} segi_result_t;

	segi_result_t pending[$];
	int errors;

	// x + dv*c/d in fixed point, truncated toward zero
	function bit [31:0] fix_axis(longint base, longint dv, longint c, longint d);
		logic signed [127:0] num;
		logic signed [127:0] q;
		logic signed [127:0] tot;
		num = (128'(dv) * 128'(c)) <<< 16;
		num = num + ((128'(base) <<< 16) * 128'(d));
		// signed division truncates toward zero
		tot = num / 128'(d);
		q = tot;
		return q[31:0];
	endfunction

	function int orient(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (v == 0) return 0;
		return v > 0 ? 1 : 2;
	endfunction

	function bit on_seg(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		if (px == qx && py == qy) return 0;
		if (qx == rx && qy == ry) return 0;
		return qx <= (px > rx ? px : rx) && qx >= (px < rx ? px : rx) &&
			qy <= (py > ry ? py : ry) && qy >= (py < ry ? py : ry);
	endfunction

	function void note_request(shortint x1, shortint y1, shortint x2, shortint y2,
		shortint u1, shortint v1, shortint u2, shortint v2);
		segi_result_t r;
		int o1, o2, o3, o4;
		bit hit;
		longint d, c;
		r = '{0, 0, 0, 0};
		if (!((x1 == u1 && y1 == v1) || (x1 == u2 && y1 == v2) ||
			(x2 == u1 && y2 == v1) || (x2 == u2 && y2 == v2))) begin
			o1 = orient(x1, y1, x2, y2, u1, v1);
			o2 = orient(x1, y1, x2, y2, u2, v2);
			o3 = orient(u1, v1, u2, v2, x1, y1);
			o4 = orient(u1, v1, u2, v2, x2, y2);
			hit = (o1 != o2 && o3 != o4) ||
				(o1 == 0 && on_seg(x1, y1, u1, v1, x2, y2)) ||
				(o2 == 0 && on_seg(x1, y1, u2, v2, x2, y2)) ||
				(o3 == 0 && on_seg(u1, v1, x1, y1, u2, v2)) ||
				(o4 == 0 && on_seg(u1, v1, x2, y2, u2, v2));
			if (hit) begin
				r.crosses = 1;
				d = (longint'(x1) - x2) * (longint'(v1) - v2) -
					(longint'(y1) - y2) * (longint'(u1) - u2);
				c = (longint'(u1) - x1) * (longint'(v2) - y1) -
					(longint'(v1) - y1) * (longint'(u2) - x1);
				if (d == 0) r.degenerate = 1;
				else begin
					r.ix = fix_axis(x1, longint'(x2) - x1, c, d);
					r.iy = fix_axis(y1, longint'(y2) - y1, c, d);
				end
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(bit cr, bit dg, bit [31:0] x, bit [31:0] y);
		segi_result_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %b %b %h %h", cr, dg, x, y);
			return;
		end
		e = pending.pop_front();
		if (e.crosses !== cr || e.degenerate !== dg || e.ix !== x || e.iy !== y) begin
			errors++;
			if (errors <= 10)
				$display("mismatch exp %b %b %h %h got %b %b %h %h",
					e.crosses, e.degenerate, e.ix, e.iy, cr, dg, x, y);
		end
	endfunction
endclass

module segment_intersection_unit_tb;
	import segi_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	logic out_valid;
	logic out_stall;
	logic crosses, degenerate;
	logic signed [OUT_WIDTH-1:0] ix, iy;

	segi_scoreboard board;
	bit quiet;
	int cycles;

	segment_intersection_unit uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.ax1(ax1), .ay1(ay1), .ax2(ax2), .ay2(ay2),
		.bx1(bx1), .by1(by1), .bx2(bx2), .by2(by2),
		.out_valid(out_valid), .out_stall(out_stall),
		.crosses(crosses), .degenerate(degenerate), .ix(ix), .iy(iy)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		in_valid = 0;
		out_stall = 0;
		{ax1, ay1, ax2, ay2, bx1, by1, bx2, by2} = '0;
		arst_n = 0;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// result side: random stall bursts, checks on accept
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 17);
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(crosses, degenerate, ix, iy);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end
	initial cycles = 0;

	task send_request(input shortint x1, y1, x2, y2, u1, v1, u2, v2);
		int n;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 17);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		ax1 <= x1; ay1 <= y1; ax2 <= x2; ay2 <= y2;
		bx1 <= u1; by1 <= v1; bx2 <= u2; by2 <= v2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(x1, y1, x2, y2, u1, v1, u2, v2);
	endtask

	function shortint rnd_coord(int span);
		if (span >= 32768) return shortint'($urandom);
		return shortint'($urandom_range(0, 2 * span) - span);
	endfunction

	initial begin
		shortint p[8];
		int span;
		int t;
		quiet = 0;
		@(posedge arst_n);
		@(posedge clk);
		// plain cross, extremes, shared ends, probes at ends, collinear, zero length
		send_request(0, 0, 10, 10, 0, 10, 10, 0);
		send_request(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_request(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		send_request(0, 0, 10, 10, 10, 10, 20, 0);
		send_request(0, 0, 10, 0, 5, 0, 5, 5);
		send_request(0, 0, 10, 0, 20, 0, 30, 0);
		send_request(0, 0, 10, 0, 5, 0, 15, 0);
		send_request(0, 0, 10, 0, 0, 0, 0, 0);
		send_request(5, 0, 5, 0, 0, 0, 10, 0);
		send_request(3, 3, 3, 3, 3, 3, 3, 3);
		send_request(0, 0, 3, 7, 0, 1, 3, 0);
		send_request(-1, -1, -7, -3, -1, -3, -7, -1);
		send_request(0, 0, 10, 0, 10, 0, 5, 0);
		send_request(0, 0, 1, 1, 0, 5, 5, 0);
		send_request(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
		send_request(16'sh5555, 16'sh2aaa, -16'sh5555, -16'sh2aaa, 1, -1, -1, 1);
		for (int i = 0; i < 650; i++) begin
			if (i > 560) quiet = 1;
			t = $urandom_range(0, 9);
			span = (t < 3) ? 8 : (t < 6) ? 300 : 40000;
			foreach (p[k]) p[k] = rnd_coord(span);
			// now and then the second segment starts where the first one ends
			if (t == 9) begin
				p[4] = p[2]; p[5] = p[3];
			end
			send_request(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
		end
		in_valid <= 0;
		quiet = 1;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
